// ===== hdl/inverse_fitness_roulette_select_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef INVERSE_FITNESS_ROULETTE_SELECT_MACROS_SVH
`define INVERSE_FITNESS_ROULETTE_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ifrs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IFRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ifrs assertion failed");

`endif

// ===== hdl/ifrs_pkg.sv =====
package ifrs_pkg;

    // Population storage.
    localparam int POP_SIZE  = 64;
    localparam int IDX_W     = $clog2(POP_SIZE);
    localparam int CNT_W     = IDX_W + 1;

    // Field and weight widths.
    localparam int ACT_W     = 2;
    localparam int FIT_W     = 16;
    localparam int RAND_BITS = 16;
    localparam int W_W       = 32;
    localparam int TOT_W     = W_W + IDX_W;
    localparam int HI_W      = TOT_W - RAND_BITS;
    localparam int STEP_W    = $clog2(W_W);

    // The fixed-point value 1.0 is the all-ones weight.
    localparam logic [W_W-1:0] WEIGHT_ONE = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_DRAW  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef enum logic {
        STAT_OK    = 1'b0,
        STAT_EMPTY = 1'b1
    } t_status;

endpackage

// ===== hdl/ifrs_if.sv =====
// Input channel: one item per action.
interface ifrs_item_if
    import ifrs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [FIT_W-1:0] fitness;
    logic [RAND_BITS-1:0] random_fraction;

    modport source (output valid, output action, output fitness, output random_fraction,
                    input ready);
    modport sink   (input valid, input action, input fitness, input random_fraction,
                    output ready);
endinterface

// Result channel: one item per draw.
interface ifrs_result_if
    import ifrs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] selected_index;
    logic             status;

    modport source (output valid, output selected_index, output status, input ready);
    modport sink   (input valid, input selected_index, input status, output ready);
endinterface

// ===== hdl/inverse_fitness_roulette_select.sv =====
// Channel    Dir  Handshake     Payload
// i_item     in   valid/ready   action, fitness, random_fraction
// o_result   out  valid/ready   selected_index, status
//
// One item is worked on at a time; i_item.ready is high only while idle.
// A load of a nonzero fitness runs the bit-serial reciprocal divider (ST_DIV);
// a zero fitness, a full store, a clear or an unused code finish in ST_IDLE.
// A draw passes through ST_MUL, ST_ADD and ST_SCAN to ST_OUT: the scan reads
// the weight memory once per cycle. An empty draw goes straight to ST_OUT.
// Reset empties the population; the weight memory is not cleared.
// A stalled result waits in the output register; a new item is taken meanwhile.
module inverse_fitness_roulette_select
    import ifrs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ifrs_item_if.sink     i_item,
    ifrs_result_if.source o_result
);

    // Weight memory, one synchronous read port and one write port.
    logic [W_W-1:0]   mem [POP_SIZE];
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [W_W-1:0]   mem_wd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [W_W-1:0]   r_rdata;

    // Control and datapath registers.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [FIT_W-1:0]   r_div, n_div;
    logic [FIT_W-1:0]   r_rem, n_rem;
    logic [W_W-1:0]     r_quo, n_quo;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [RAND_BITS-1:0] r_frac, n_frac;
    logic [TOT_W-1:0]   r_prod_hi;
    logic [2*RAND_BITS-1:0] r_prod_lo;
    logic [TOT_W-1:0]   r_target, n_target;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_rd_valid, n_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [TOT_W-1:0]   r_cum, n_cum;
    logic [IDX_W-1:0]   r_pick, n_pick;
    logic               r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_status;
    logic               out_load;

    // Divider step and scan helpers.
    logic [FIT_W:0]     rem_sh;
    logic               rem_ge;
    logic [W_W-1:0]     quo_nx;
    logic [TOT_W-1:0]   cum_nx;
    logic               in_accept;

    assign in_accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == ST_IDLE);

    assign o_result.valid          = r_out_valid;
    assign o_result.selected_index = r_out_idx;
    assign o_result.status         = r_out_status;

    // Restoring division of all ones by the fitness: the shifted-in
    // dividend bit is always one.
    always_comb begin
        rem_sh = {r_rem, 1'b1};
        rem_ge = (rem_sh >= {1'b0, r_div});
        quo_nx = {r_quo[W_W-2:0], rem_ge};
    end

    assign cum_nx = r_cum + TOT_W'(r_rdata);

    // Next state, memory controls and result selection.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_frac      = r_frac;
        n_target    = r_target;
        n_addr      = r_addr;
        n_rd_valid  = 1'b0;
        n_cum       = r_cum;
        n_pick      = r_pick;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_wa      = r_cnt[IDX_W-1:0];
        mem_wd      = WEIGHT_ONE;
        rd_en       = 1'b0;
        rd_addr     = r_addr[IDX_W-1:0];
        out_load    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (i_item.action)
                        ACT_LOAD: begin
                            if (r_cnt != CNT_W'(POP_SIZE)) begin
                                if (i_item.fitness == '0) begin
                                    mem_we  = 1'b1;
                                    n_cnt   = r_cnt + 1'b1;
                                    n_total = r_total + TOT_W'(WEIGHT_ONE);
                                end else begin
                                    n_div   = i_item.fitness;
                                    n_rem   = '0;
                                    n_quo   = '0;
                                    n_step  = '0;
                                    n_state = ST_DIV;
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_cnt   = '0;
                            n_total = '0;
                        end
                        ACT_DRAW: begin
                            if (r_cnt == '0) begin
                                n_pick   = '0;
                                n_status = STAT_EMPTY;
                                n_state  = ST_OUT;
                            end else begin
                                n_frac  = i_item.random_fraction;
                                n_state = ST_MUL;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem  = rem_ge ? FIT_W'(rem_sh - {1'b0, r_div}) : FIT_W'(rem_sh);
                n_quo  = quo_nx;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(W_W - 1)) begin
                    mem_we  = 1'b1;
                    mem_wd  = quo_nx;
                    n_cnt   = r_cnt + 1'b1;
                    n_total = r_total + TOT_W'(quo_nx);
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_target = r_prod_hi + TOT_W'(r_prod_lo[2*RAND_BITS-1:RAND_BITS]);
                n_addr   = '0;
                n_cum    = '0;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                // Each read's data is compared in the cycle after it is issued.
                if (r_addr < r_cnt) begin
                    rd_en      = 1'b1;
                    n_rd_valid = 1'b1;
                    n_addr     = r_addr + 1'b1;
                end
                if (r_rd_valid) begin
                    n_cum = cum_nx;
                    if (cum_nx >= r_target || {1'b0, r_rd_idx} == r_cnt - 1'b1) begin
                        n_pick     = r_rd_idx;
                        n_status   = STAT_OK;
                        n_rd_valid = 1'b0;
                        rd_en      = 1'b0;
                        n_state    = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output register handshake.
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_total     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_div     <= n_div;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_frac    <= n_frac;
        r_target  <= n_target;
        r_addr    <= n_addr;
        r_cum     <= n_cum;
        r_pick    <= n_pick;
        r_status  <= n_status;
        r_rd_idx  <= r_addr[IDX_W-1:0];
        // Target split into high and low partial products.
        r_prod_hi <= {{RAND_BITS{1'b0}}, r_total[TOT_W-1:RAND_BITS]} *
                     {{HI_W{1'b0}}, r_frac};
        r_prod_lo <= r_total[RAND_BITS-1:0] * r_frac;
        if (out_load) begin
            r_out_idx    <= r_pick;
            r_out_status <= r_status;
        end
    end

    // Weight memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ifrs_checker.sv =====
`include "inverse_fitness_roulette_select_macros.svh"

module ifrs_checker
    import ifrs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [ACT_W-1:0] i_action,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [IDX_W-1:0] i_selected_index,
    input logic             i_status
);

    // A stalled result stays offered.
    `IFRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled result keeps its payload.
    `IFRS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_selected_index) && $stable(i_status))

    // An empty population always reports index zero.
    `IFRS_ASSERT_SAME(a_empty_idx, i_clk, i_rst_n, i_out_valid && i_status == STAT_EMPTY, i_selected_index == '0)

    // A draw keeps the input closed in the following cycle.
    `IFRS_ASSERT_NEXT(a_draw_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_action == ACT_DRAW, !i_in_ready)

endmodule

bind inverse_fitness_roulette_select ifrs_checker u_ifrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_action         (i_item.action),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_selected_index (o_result.selected_index),
    .i_status         (o_result.status)
);

// ===== bench/inverse_fitness_roulette_select_tb.sv =====
`timescale 1ns / 1ps

import ifrs_pkg::*;

// Tracks the population as the block should see it and holds the picks still owed.
class roulette_tracker;
    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_status          status;
    } pick_t;

    logic [W_W-1:0]   weights [POP_SIZE];
    logic [CNT_W-1:0] entries = '0;
    logic [TOT_W-1:0] total = '0;
    pick_t            pending_picks [$];
    int unsigned      failures = 0;

    // Weight of one individual: 1.0 divided by its fitness, saturating at zero fitness.
    function automatic logic [W_W-1:0] inverse_weight(logic [FIT_W-1:0] fit);
        if (fit == '0) begin
            return WEIGHT_ONE;
        end
        return WEIGHT_ONE / W_W'(fit);
    endfunction

    // Applies one accepted item to the population and queues the pick a draw owes.
    function void note_item(logic [ACT_W-1:0] act, logic [FIT_W-1:0] fit,
                            logic [RAND_BITS-1:0] frac);
        logic [TOT_W+RAND_BITS-1:0] product;
        logic [TOT_W-1:0]           target;
        logic [TOT_W-1:0]           running;
        logic [W_W-1:0]             w;
        pick_t                      pick;
        case (act)
            ACT_LOAD: begin
                if (entries < POP_SIZE) begin
                    w = inverse_weight(fit);
                    weights[entries[IDX_W-1:0]] = w;
                    total = total + TOT_W'(w);
                    entries = entries + 1'b1;
                end
            end
            ACT_CLEAR: begin
                entries = '0;
                total = '0;
            end
            ACT_DRAW: begin
                if (entries == '0) begin
                    pick.index = '0;
                    pick.status = STAT_EMPTY;
                end else begin
                    product = total * frac;
                    target = product[TOT_W+RAND_BITS-1:RAND_BITS];
                    pick.index = IDX_W'(entries - 1'b1);
                    pick.status = STAT_OK;
                    running = '0;
                    // The first entry whose running sum reaches the target wins.
                    for (int i = 0; i < entries; i++) begin
                        running = running + TOT_W'(weights[i]);
                        if (running >= target) begin
                            pick.index = IDX_W'(i);
                            break;
                        end
                    end
                end
                pending_picks.push_back(pick);
            end
            default: begin
            end
        endcase
    endfunction

    // Compares one result item with the oldest pick still owed.
    function void check_pick(logic [IDX_W-1:0] index, logic status);
        pick_t want;
        if (pending_picks.size() == 0) begin
            $error("unexpected result: selected_index %0d status %0d", index, status);
            failures++;
            return;
        end
        want = pending_picks.pop_front();
        if (index !== want.index) begin
            $error("selected_index mismatch: expected %0d, actual %0d", want.index, index);
            failures++;
        end
        if (status !== logic'(want.status)) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            failures++;
        end
    endfunction
endclass

module inverse_fitness_roulette_select_tb;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 100;

    logic i_clk;
    logic i_rst_n;

    ifrs_item_if   item_if ();
    ifrs_result_if result_if ();

    inverse_fitness_roulette_select dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    roulette_tracker tracker = new();

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int fill = 0;
    int useful_items = 0;
    int cycles = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Watch both channels; results are checked before a new item is noted.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_if.valid && result_if.ready) begin
            tracker.check_pick(result_if.selected_index, result_if.status);
        end
        if (i_rst_n === 1'b1 && item_if.valid && item_if.ready) begin
            tracker.note_item(item_if.action, item_if.fitness, item_if.random_fraction);
        end
    end

    // Result side: stall a random number of cycles before taking each item.
    initial begin
        int stall;
        result_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_if.valid) @(posedge i_clk);
        end
    end

    // Offers one item after a random gap and returns once it is accepted.
    task automatic send_item(logic [ACT_W-1:0] act, logic [FIT_W-1:0] fit,
                             logic [RAND_BITS-1:0] frac);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.action          <= act;
        item_if.fitness         <= fit;
        item_if.random_fraction <= frac;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        // Only items that do something count toward the run length.
        case (act)
            ACT_LOAD: begin
                if (fill < POP_SIZE) begin
                    fill++;
                    useful_items++;
                end
            end
            ACT_CLEAR: begin
                fill = 0;
                useful_items++;
            end
            ACT_DRAW: useful_items++;
            default: begin
            end
        endcase
    endtask

    task automatic send_load(logic [FIT_W-1:0] fit);
        send_item(ACT_LOAD, fit, RAND_BITS'($urandom));
    endtask

    task automatic send_draw(logic [RAND_BITS-1:0] frac);
        send_item(ACT_DRAW, FIT_W'($urandom), frac);
    endtask

    // Hold the input side until every owed pick has come back.
    task automatic drain_picks();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_picks.size() != 0) @(posedge i_clk);
    endtask

    // Fitness values spread over several decades so weights differ widely.
    function automatic logic [FIT_W-1:0] random_fitness();
        case ($urandom_range(0, 5))
            0: return FIT_W'($urandom_range(0, 3));
            1: return FIT_W'($urandom_range(0, 31));
            2: return FIT_W'($urandom_range(0, 1023));
            3: return FIT_W'(16'hFFFF - $urandom_range(0, 15));
            default: return FIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAND_BITS-1:0] random_fraction();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RAND_BITS'($urandom_range(0, 255));
            default: return RAND_BITS'($urandom);
        endcase
    endfunction

    // Reset, a directed opening, then random populations with draws.
    initial begin
        int n;
        int r;
        bit uniform;
        logic [FIT_W-1:0] common_fit;

        i_rst_n                 = 1'b0;
        item_if.valid           = 1'b0;
        item_if.action          = ACT_LOAD;
        item_if.fitness         = '0;
        item_if.random_fraction = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty draw, saturating and extreme loads, zero and full targets.
        send_draw(16'h1234);
        send_load(16'h0000);
        send_load(16'h0001);
        send_load(16'hFFFF);
        send_load(16'h0002);
        send_load(16'h0003);
        send_draw(16'h0000);
        send_draw(16'hFFFF);
        send_draw(16'h8000);
        send_draw(16'h0001);
        send_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        send_draw(16'h4000);
        drain_picks();
        send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        send_draw(16'hFFFF);
        send_load(16'hFFFF);
        send_draw(16'hFFFF);
        send_draw(16'h0000);
        send_load(16'h0000);
        send_load(16'h0000);
        send_draw(16'hFFFF);
        send_draw(16'h5555);

        // Each round builds a population, draws from it and adds some noise.
        while (useful_items < TARGET_ITEMS) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) != 0) begin
                send_item(ACT_CLEAR, FIT_W'($urandom), RAND_BITS'($urandom));
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                n = $urandom_range(60, 70);
            end else if (r <= 3) begin
                n = $urandom_range(9, 30);
            end else begin
                n = $urandom_range(1, 8);
            end
            uniform = ($urandom_range(0, 5) == 0);
            common_fit = random_fitness();
            repeat (n) begin
                send_load(uniform ? common_fit : random_fitness());
            end
            repeat ($urandom_range(1, 10)) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_item(ACT_UNUSED, FIT_W'($urandom), RAND_BITS'($urandom));
                end else if (r == 1) begin
                    send_load(random_fitness());
                end else if (r == 2) begin
                    send_item(ACT_CLEAR, FIT_W'($urandom), RAND_BITS'($urandom));
                    send_draw(random_fraction());
                end else begin
                    send_draw(random_fraction());
                end
            end
            if ($urandom_range(0, 15) == 0) begin
                drain_picks();
            end
        end

        // Stop offering, collect what is owed, then give the block time to misbehave.
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.pending_picks.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== inverse_fitness_roulette_select.f =====
+incdir+hdl
hdl/ifrs_pkg.sv
hdl/ifrs_if.sv
hdl/inverse_fitness_roulette_select.sv
hdl/ifrs_checker.sv
bench/inverse_fitness_roulette_select_tb.sv
